[design/oprs_pkg.sv]
// shared types and constants for the oled page refresh sequencer
package oprs_pkg;

    localparam int PAGE_COUNT = 8;

    localparam logic [3:0] PH_OFF          = 4'd0;
    localparam logic [3:0] PH_RETRY        = 4'd1;
    localparam logic [3:0] PH_START_INIT   = 4'd2;
    localparam logic [3:0] PH_WAIT_INIT    = 4'd3;
    localparam logic [3:0] PH_READY        = 4'd4;
    localparam logic [3:0] PH_START_CURSOR = 4'd5;
    localparam logic [3:0] PH_WAIT_CURSOR  = 4'd6;
    localparam logic [3:0] PH_WAIT_PAGE    = 4'd7;
    localparam logic [3:0] PH_START_ON     = 4'd8;
    localparam logic [3:0] PH_WAIT_ON      = 4'd9;

    localparam logic [2:0] XFER_NONE   = 3'd0;
    localparam logic [2:0] XFER_INIT   = 3'd1;
    localparam logic [2:0] XFER_CURSOR = 3'd2;
    localparam logic [2:0] XFER_PAGE   = 3'd3;
    localparam logic [2:0] XFER_ON     = 3'd4;

    localparam logic [0:0] OP_SERVICE = 1'b0;
    localparam logic [0:0] OP_RESTART = 1'b1;

    localparam logic [6:0] ADDR_PRIMARY   = 7'h3C;
    localparam logic [6:0] ADDR_ALTERNATE = 7'h3D;
    localparam logic [6:0] ADDR_LOW       = 7'd8;
    localparam logic [6:0] ADDR_HIGH      = 7'd119;

    localparam logic [1:0] CFG_START_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_RENDER_PERIOD = 2'd1;
    localparam logic [1:0] CFG_RETRY_PERIOD  = 2'd2;

    localparam logic [6:0]  RST_START_ADDRESS = 7'd60;
    localparam logic [15:0] RST_RENDER_PERIOD = 16'd250;
    localparam logic [15:0] RST_RETRY_PERIOD  = 16'd1000;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [31:0] now_time;
        logic        bus_ready;
        logic        bus_error;
        logic        bus_nack;
        logic        start_ok;
        logic [3:0]  keys;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  transfer_kind;
        logic [2:0]  page_index;
        logic [6:0]  bus_address;
        logic        render_strobe;
        logic        panel_on;
        logic [15:0] failure_count;
        logic [3:0]  phase;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  start_address;
        logic [15:0] render_period_ms;
        logic [15:0] retry_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  seq_phase;
        logic [6:0]  current_address;
        logic [31:0] last_render_time;
        logic [31:0] retry_start_time;
        logic        redraw_wanted;
        logic [3:0]  page_counter;
        logic        first_frame_done;
        logic        panel_on_flag;
        logic [15:0] failure_counter;
        logic [3:0]  last_keys;
    } seq_state_t;

endpackage

[design/oled_page_refresh_sequencer.sv]
// top level of the oled page refresh sequencer: request registers, state and result register
// a request waits in the request register, then its result is loaded into the result register
// throughput: one request per cycle unless m_ready stalls; the step logic sits between input and result registers
// the sequencer state is updated in the same cycle the result register is loaded
// reset: synchronous active-low aresetn clears the state to off, address 60, counters zero,
// and the configuration to address 60, render period 250 ms, retry period 1000 ms
module oled_page_refresh_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  oprs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output oprs_pkg::out_item_t m_data
);

    oprs_pkg::cfg_t       cfg_reg;
    oprs_pkg::seq_state_t state_reg;
    oprs_pkg::seq_state_t state_next;
    oprs_pkg::in_item_t   in_data_reg;
    logic                 in_valid_reg;
    oprs_pkg::out_item_t  out_data_reg;
    oprs_pkg::out_item_t  out_data_next;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    oprs_step u_step (
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (out_data_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_address    <= oprs_pkg::RST_START_ADDRESS;
            cfg_reg.render_period_ms <= oprs_pkg::RST_RENDER_PERIOD;
            cfg_reg.retry_period_ms  <= oprs_pkg::RST_RETRY_PERIOD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                oprs_pkg::CFG_START_ADDRESS: cfg_reg.start_address    <= cfg_wr_data[6:0];
                oprs_pkg::CFG_RENDER_PERIOD: cfg_reg.render_period_ms <= cfg_wr_data;
                oprs_pkg::CFG_RETRY_PERIOD:  cfg_reg.retry_period_ms  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.seq_phase        <= oprs_pkg::PH_OFF;
            state_reg.current_address  <= oprs_pkg::RST_START_ADDRESS;
            state_reg.last_render_time <= 32'd0;
            state_reg.retry_start_time <= 32'd0;
            state_reg.redraw_wanted    <= 1'b0;
            state_reg.page_counter     <= 4'd0;
            state_reg.first_frame_done <= 1'b0;
            state_reg.panel_on_flag    <= 1'b0;
            state_reg.failure_counter  <= 16'd0;
            state_reg.last_keys        <= 4'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[design/oprs_step.sv]
// next-state and result logic for one service step or restart request
module oprs_step (
    input  oprs_pkg::in_item_t   item,
    input  oprs_pkg::cfg_t       cfg,
    input  oprs_pkg::seq_state_t cur,
    output oprs_pkg::seq_state_t nxt,
    output oprs_pkg::out_item_t  result
);

    logic        failed;
    logic        retry_due;
    logic        render_due;
    logic        go_fail;
    logic        go_frame;
    logic [2:0]  kind;
    logic [2:0]  page;
    logic        strobe;
    logic [31:0] retry_elapsed;
    logic [31:0] render_elapsed;

    assign failed         = item.bus_ready & item.bus_error;
    assign retry_elapsed  = item.now_time - cur.retry_start_time;
    assign render_elapsed = item.now_time - cur.last_render_time;
    assign retry_due      = retry_elapsed >= {16'd0, cfg.retry_period_ms};
    assign render_due     = render_elapsed >= {16'd0, cfg.render_period_ms};

    always_comb begin
        nxt      = cur;
        kind     = oprs_pkg::XFER_NONE;
        page     = 3'd0;
        strobe   = 1'b0;
        go_fail  = 1'b0;
        go_frame = 1'b0;

        if (item.opcode == oprs_pkg::OP_RESTART) begin
            if (cfg.start_address >= oprs_pkg::ADDR_LOW
                    && cfg.start_address <= oprs_pkg::ADDR_HIGH) begin
                nxt.current_address  = cfg.start_address;
                nxt.last_keys        = 4'd0;
                nxt.page_counter     = 4'd0;
                nxt.first_frame_done = 1'b0;
                nxt.panel_on_flag    = 1'b0;
                nxt.failure_counter  = 16'd0;
                nxt.redraw_wanted    = 1'b1;
                nxt.last_render_time = item.now_time - {16'd0, cfg.render_period_ms};
                nxt.retry_start_time = item.now_time;
                nxt.seq_phase        = oprs_pkg::PH_RETRY;
            end
        end else if (cur.seq_phase != oprs_pkg::PH_OFF) begin
            if (item.keys != cur.last_keys) begin
                nxt.last_keys     = item.keys;
                nxt.redraw_wanted = 1'b1;
            end
            unique case (cur.seq_phase)
                oprs_pkg::PH_RETRY: begin
                    if (retry_due) begin
                        nxt.seq_phase = oprs_pkg::PH_START_INIT;
                    end
                end
                oprs_pkg::PH_START_INIT: begin
                    if (item.bus_ready && item.start_ok) begin
                        kind          = oprs_pkg::XFER_INIT;
                        nxt.seq_phase = oprs_pkg::PH_WAIT_INIT;
                    end
                end
                oprs_pkg::PH_WAIT_INIT: begin
                    if (item.bus_ready) begin
                        if (failed) begin
                            go_fail = 1'b1;
                        end else begin
                            go_frame = 1'b1;
                        end
                    end
                end
                oprs_pkg::PH_READY: begin
                    if (nxt.redraw_wanted || render_due) begin
                        go_frame = 1'b1;
                    end
                end
                oprs_pkg::PH_START_CURSOR: begin
                    if (cur.page_counter >= 4'(oprs_pkg::PAGE_COUNT)) begin
                        if (!cur.first_frame_done) begin
                            nxt.first_frame_done = 1'b1;
                            nxt.seq_phase        = oprs_pkg::PH_START_ON;
                        end else begin
                            nxt.seq_phase = oprs_pkg::PH_READY;
                        end
                    end else if (item.bus_ready && item.start_ok) begin
                        kind          = oprs_pkg::XFER_CURSOR;
                        page          = cur.page_counter[2:0];
                        nxt.seq_phase = oprs_pkg::PH_WAIT_CURSOR;
                    end
                end
                oprs_pkg::PH_WAIT_CURSOR: begin
                    if (item.bus_ready) begin
                        if (failed) begin
                            go_fail = 1'b1;
                        end else if (item.start_ok) begin
                            kind          = oprs_pkg::XFER_PAGE;
                            page          = cur.page_counter[2:0];
                            nxt.seq_phase = oprs_pkg::PH_WAIT_PAGE;
                        end
                    end
                end
                oprs_pkg::PH_WAIT_PAGE: begin
                    if (item.bus_ready) begin
                        if (failed) begin
                            go_fail = 1'b1;
                        end else begin
                            nxt.page_counter = cur.page_counter + 4'd1;
                            nxt.seq_phase    = oprs_pkg::PH_START_CURSOR;
                        end
                    end
                end
                oprs_pkg::PH_START_ON: begin
                    if (item.bus_ready && item.start_ok) begin
                        kind          = oprs_pkg::XFER_ON;
                        nxt.seq_phase = oprs_pkg::PH_WAIT_ON;
                    end
                end
                oprs_pkg::PH_WAIT_ON: begin
                    if (item.bus_ready) begin
                        if (failed) begin
                            go_fail = 1'b1;
                        end else begin
                            nxt.panel_on_flag = 1'b1;
                            nxt.seq_phase     = oprs_pkg::PH_READY;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (go_fail) begin
                if (item.bus_nack) begin
                    nxt.current_address = (cur.current_address == oprs_pkg::ADDR_PRIMARY)
                                          ? oprs_pkg::ADDR_ALTERNATE
                                          : oprs_pkg::ADDR_PRIMARY;
                end
                nxt.panel_on_flag    = 1'b0;
                nxt.first_frame_done = 1'b0;
                nxt.retry_start_time = item.now_time;
                nxt.failure_counter  = cur.failure_counter + 16'd1;
                nxt.seq_phase        = oprs_pkg::PH_RETRY;
            end
            if (go_frame) begin
                strobe               = 1'b1;
                nxt.last_render_time = item.now_time;
                nxt.redraw_wanted    = 1'b0;
                nxt.page_counter     = 4'd0;
                nxt.seq_phase        = oprs_pkg::PH_START_CURSOR;
            end
        end

        result.transfer_kind = kind;
        result.page_index    = page;
        result.bus_address   = nxt.current_address;
        result.render_strobe = strobe;
        result.panel_on      = nxt.panel_on_flag;
        result.failure_count = nxt.failure_counter;
        result.phase         = nxt.seq_phase;
    end

endmodule

[tb/sv/tb.sv]
// testbench for the oled page refresh sequencer: directed bring-up cases and random bus traffic
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    oprs_pkg::in_item_t   s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    oprs_pkg::out_item_t  m_data;

    oprs_pkg::seq_state_t panel_st;
    oprs_pkg::cfg_t       panel_cfg;
    oprs_pkg::out_item_t  panel_results_q [$];
    oprs_pkg::out_item_t  want_res;

    logic [31:0] now_ms = '0;
    logic [3:0]  held_keys = '0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          mismatches = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          kind_count [0:7];

    oled_page_refresh_sequencer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic period_elapsed(input logic [31:0] now, input logic [31:0] since,
                                            input logic [15:0] period);
        logic [31:0] gap;
        gap = now - since;
        return gap >= {16'd0, period};
    endfunction

    function automatic void take_bus_failure(input logic [31:0] now, input logic nack);
        if (nack) begin
            panel_st.current_address =
                (panel_st.current_address == oprs_pkg::ADDR_PRIMARY) ?
                oprs_pkg::ADDR_ALTERNATE : oprs_pkg::ADDR_PRIMARY;
        end
        panel_st.panel_on_flag = 1'b0;
        panel_st.first_frame_done = 1'b0;
        panel_st.retry_start_time = now;
        panel_st.failure_counter = panel_st.failure_counter + 16'd1;
        panel_st.seq_phase = oprs_pkg::PH_RETRY;
    endfunction

    function automatic void start_frame(input logic [31:0] now);
        panel_st.last_render_time = now;
        panel_st.redraw_wanted = 1'b0;
        panel_st.page_counter = '0;
        panel_st.seq_phase = oprs_pkg::PH_START_CURSOR;
    endfunction

    // one service step or restart of the panel sequencer
    function automatic oprs_pkg::out_item_t panel_step(input oprs_pkg::in_item_t req);
        oprs_pkg::out_item_t res;
        logic [2:0]          kind;
        logic [2:0]          page;
        logic                strobe;
        logic                failed;
        kind = oprs_pkg::XFER_NONE;
        page = '0;
        strobe = 1'b0;
        failed = req.bus_ready && req.bus_error;
        if (req.opcode == oprs_pkg::OP_RESTART) begin
            if (panel_cfg.start_address >= oprs_pkg::ADDR_LOW &&
                panel_cfg.start_address <= oprs_pkg::ADDR_HIGH) begin
                panel_st.current_address = panel_cfg.start_address;
                panel_st.last_keys = '0;
                panel_st.page_counter = '0;
                panel_st.first_frame_done = 1'b0;
                panel_st.panel_on_flag = 1'b0;
                panel_st.failure_counter = '0;
                panel_st.redraw_wanted = 1'b1;
                panel_st.last_render_time = req.now_time - {16'd0, panel_cfg.render_period_ms};
                panel_st.retry_start_time = req.now_time;
                panel_st.seq_phase = oprs_pkg::PH_RETRY;
            end
        end else if (panel_st.seq_phase != oprs_pkg::PH_OFF) begin
            if (req.keys != panel_st.last_keys) begin
                panel_st.last_keys = req.keys;
                panel_st.redraw_wanted = 1'b1;
            end
            case (panel_st.seq_phase)
                oprs_pkg::PH_RETRY: begin
                    if (period_elapsed(req.now_time, panel_st.retry_start_time,
                                       panel_cfg.retry_period_ms)) begin
                        panel_st.seq_phase = oprs_pkg::PH_START_INIT;
                    end
                end
                oprs_pkg::PH_START_INIT: begin
                    if (req.bus_ready && req.start_ok) begin
                        kind = oprs_pkg::XFER_INIT;
                        panel_st.seq_phase = oprs_pkg::PH_WAIT_INIT;
                    end
                end
                oprs_pkg::PH_WAIT_INIT: begin
                    if (failed) begin
                        take_bus_failure(req.now_time, req.bus_nack);
                    end else if (req.bus_ready) begin
                        strobe = 1'b1;
                        start_frame(req.now_time);
                    end
                end
                oprs_pkg::PH_READY: begin
                    if (panel_st.redraw_wanted ||
                        period_elapsed(req.now_time, panel_st.last_render_time,
                                       panel_cfg.render_period_ms)) begin
                        strobe = 1'b1;
                        start_frame(req.now_time);
                    end
                end
                oprs_pkg::PH_START_CURSOR: begin
                    if (panel_st.page_counter >= 4'(oprs_pkg::PAGE_COUNT)) begin
                        if (!panel_st.first_frame_done) begin
                            panel_st.first_frame_done = 1'b1;
                            panel_st.seq_phase = oprs_pkg::PH_START_ON;
                        end else begin
                            panel_st.seq_phase = oprs_pkg::PH_READY;
                        end
                    end else if (req.bus_ready && req.start_ok) begin
                        kind = oprs_pkg::XFER_CURSOR;
                        page = panel_st.page_counter[2:0];
                        panel_st.seq_phase = oprs_pkg::PH_WAIT_CURSOR;
                    end
                end
                oprs_pkg::PH_WAIT_CURSOR: begin
                    if (failed) begin
                        take_bus_failure(req.now_time, req.bus_nack);
                    end else if (req.bus_ready && req.start_ok) begin
                        kind = oprs_pkg::XFER_PAGE;
                        page = panel_st.page_counter[2:0];
                        panel_st.seq_phase = oprs_pkg::PH_WAIT_PAGE;
                    end
                end
                oprs_pkg::PH_WAIT_PAGE: begin
                    if (failed) begin
                        take_bus_failure(req.now_time, req.bus_nack);
                    end else if (req.bus_ready) begin
                        panel_st.page_counter = panel_st.page_counter + 4'd1;
                        panel_st.seq_phase = oprs_pkg::PH_START_CURSOR;
                    end
                end
                oprs_pkg::PH_START_ON: begin
                    if (req.bus_ready && req.start_ok) begin
                        kind = oprs_pkg::XFER_ON;
                        panel_st.seq_phase = oprs_pkg::PH_WAIT_ON;
                    end
                end
                oprs_pkg::PH_WAIT_ON: begin
                    if (failed) begin
                        take_bus_failure(req.now_time, req.bus_nack);
                    end else if (req.bus_ready) begin
                        panel_st.panel_on_flag = 1'b1;
                        panel_st.seq_phase = oprs_pkg::PH_READY;
                    end
                end
                default: begin
                end
            endcase
        end
        res.transfer_kind = kind;
        res.page_index = page;
        res.bus_address = panel_st.current_address;
        res.render_strobe = strobe;
        res.panel_on = panel_st.panel_on_flag;
        res.failure_count = panel_st.failure_counter;
        res.phase = panel_st.seq_phase;
        return res;
    endfunction

    function automatic oprs_pkg::in_item_t svc_req(input logic [0:0] op, input logic [31:0] t,
                                                   input logic rdy, input logic err,
                                                   input logic nack, input logic ok,
                                                   input logic [3:0] k);
        oprs_pkg::in_item_t req;
        req.opcode = op;
        req.now_time = t;
        req.bus_ready = rdy;
        req.bus_error = err;
        req.bus_nack = nack;
        req.start_ok = ok;
        req.keys = k;
        return req;
    endfunction

    task automatic send_request(input oprs_pkg::in_item_t req);
        oprs_pkg::out_item_t res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        res = panel_step(req);
        panel_results_q.push_back(res);
        kind_count[res.transfer_kind]++;
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (panel_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            oprs_pkg::CFG_START_ADDRESS: panel_cfg.start_address = value[6:0];
            oprs_pkg::CFG_RENDER_PERIOD: panel_cfg.render_period_ms = value;
            oprs_pkg::CFG_RETRY_PERIOD:  panel_cfg.retry_period_ms = value;
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_address(input logic [6:0] addr);
        set_reg(oprs_pkg::CFG_START_ADDRESS, {9'($urandom_range(0, 511)), addr});
    endtask

    // random bus traffic, mostly well-formed with occasional errors, restarts and time jumps
    task automatic run_traffic(input int count, input int idle_pct, input int stall_pct,
                               input int err_pct);
        oprs_pkg::in_item_t req;
        int                 i;
        int                 roll;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        send_request(svc_req(oprs_pkg::OP_RESTART, now_ms, 1'b1, 1'b0, 1'b0, 1'b1,
                             held_keys));
        for (i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                now_ms = now_ms + 32'($urandom_range(0, 70000));
            end else if (roll < 5) begin
                now_ms = $urandom();
            end else begin
                now_ms = now_ms + 32'($urandom_range(0, 12));
            end
            if ($urandom_range(0, 99) < 8) begin
                held_keys = 4'($urandom_range(0, 15));
            end
            req.opcode = ($urandom_range(0, 99) == 0) ? oprs_pkg::OP_RESTART
                                                       : oprs_pkg::OP_SERVICE;
            req.now_time = now_ms;
            req.bus_ready = $urandom_range(0, 99) < 75;
            req.bus_error = $urandom_range(0, 99) < err_pct;
            req.bus_nack = 1'($urandom_range(0, 1));
            req.start_ok = $urandom_range(0, 99) < 85;
            req.keys = held_keys;
            send_request(req);
            // hold off until every pending request has its result
            if (i % 150 == 149 && idle_pct != 0) begin
                wait_drained();
            end
        end
    endtask

    task automatic test_power_up_and_restart();
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0, 1'b1, 1'b0, 1'b1, 1'b1, 4'hF));
        send_request(svc_req(oprs_pkg::OP_RESTART, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 1'b0,
                             4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'hFFFF_FF00 + 32'd999,
                             1'b1, 1'b1, 1'b1, 1'b1, 4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'hFFFF_FF00 + 32'd1000,
                             1'b1, 1'b0, 1'b0, 1'b1, 4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_02E9, 1'b1, 1'b0, 1'b0, 1'b0,
                             4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_02EA, 1'b0, 1'b0, 1'b0, 1'b1,
                             4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_02EB, 1'b1, 1'b0, 1'b0, 1'b1,
                             4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_02EC, 1'b0, 1'b1, 1'b1, 1'b1,
                             4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_02ED, 1'b1, 1'b1, 1'b1, 1'b1,
                             4'h0));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1,
                             4'h5));
    endtask

    task automatic test_zero_periods();
        wait_drained();
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'd0);
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'd0);
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0400, 1'b1, 1'b0, 1'b0, 1'b1,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0400, 1'b1, 1'b0, 1'b0, 1'b1,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0401, 1'b1, 1'b0, 1'b1, 1'b1,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0402, 1'b1, 1'b0, 1'b0, 1'b1,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0403, 1'b1, 1'b0, 1'b0, 1'b0,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0404, 1'b1, 1'b0, 1'b0, 1'b1,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0405, 1'b0, 1'b0, 1'b0, 1'b1,
                             4'hA));
        send_request(svc_req(oprs_pkg::OP_SERVICE, 32'h0000_0406, 1'b1, 1'b1, 1'b0, 1'b1,
                             4'hA));
    endtask

    task automatic test_address_limits();
        logic [6:0] probe_addr [0:5];
        int         i;
        probe_addr = '{7'd0, 7'd7, 7'd120, 7'd127, oprs_pkg::ADDR_HIGH, oprs_pkg::ADDR_LOW};
        for (i = 0; i < 6; i++) begin
            wait_drained();
            set_address(probe_addr[i]);
            send_request(svc_req(oprs_pkg::OP_RESTART, 32'h0000_0500 + 32'(i),
                                 1'b1, 1'b0, 1'b0, 1'b1, 4'h0));
        end
    endtask

    task automatic test_traffic_no_idle();
        wait_drained();
        set_address(oprs_pkg::ADDR_PRIMARY);
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'd40);
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'd60);
        run_traffic(250, 0, 0, 2);
    endtask

    task automatic test_traffic_sender_idle();
        wait_drained();
        set_address(oprs_pkg::ADDR_ALTERNATE);
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'($urandom_range(1, 100)));
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'($urandom_range(1, 200)));
        run_traffic(200, 47, 0, 3);
    endtask

    task automatic test_traffic_receiver_stall();
        wait_drained();
        set_address(7'($urandom_range(8, 119)));
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'($urandom_range(1, 100)));
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'($urandom_range(1, 200)));
        run_traffic(200, 0, 47, 3);
    endtask

    task automatic test_traffic_both_idle();
        wait_drained();
        set_address(7'($urandom_range(8, 119)));
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'($urandom_range(1, 100)));
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'($urandom_range(1, 200)));
        run_traffic(200, 37, 37, 3);
    endtask

    task automatic test_period_extremes();
        wait_drained();
        set_address(oprs_pkg::ADDR_HIGH);
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'hFFFF);
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'hFFFF);
        run_traffic(100, 10, 10, 2);
        wait_drained();
        set_address(oprs_pkg::ADDR_LOW);
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'd1);
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'd1);
        run_traffic(100, 10, 10, 2);
        wait_drained();
        set_address(oprs_pkg::ADDR_ALTERNATE);
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'd0);
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'd0);
        run_traffic(100, 10, 10, 2);
    endtask

    task automatic test_time_wrap();
        wait_drained();
        set_address(oprs_pkg::ADDR_PRIMARY);
        set_reg(oprs_pkg::CFG_RENDER_PERIOD, 16'd20);
        set_reg(oprs_pkg::CFG_RETRY_PERIOD, 16'd30);
        now_ms = 32'hFFFF_FF80;
        run_traffic(100, 20, 20, 2);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (panel_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request pending, expected none actual %h",
                         $time, m_data);
            end else begin
                want_res = panel_results_q.pop_front();
                check_field("transfer_kind", 32'(want_res.transfer_kind),
                            32'(m_data.transfer_kind));
                check_field("page_index", 32'(want_res.page_index), 32'(m_data.page_index));
                check_field("bus_address", 32'(want_res.bus_address), 32'(m_data.bus_address));
                check_field("render_strobe", 32'(want_res.render_strobe),
                            32'(m_data.render_strobe));
                check_field("panel_on", 32'(want_res.panel_on), 32'(m_data.panel_on));
                check_field("failure_count", 32'(want_res.failure_count),
                            32'(m_data.failure_count));
                check_field("phase", 32'(want_res.phase), 32'(m_data.phase));
            end
        end
    end

    initial begin
        panel_st = '{seq_phase: oprs_pkg::PH_OFF,
                     current_address: oprs_pkg::RST_START_ADDRESS,
                     default: '0};
        panel_cfg = '{oprs_pkg::RST_START_ADDRESS, oprs_pkg::RST_RENDER_PERIOD,
                      oprs_pkg::RST_RETRY_PERIOD};
        foreach (kind_count[k]) kind_count[k] = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_power_up_and_restart();
        test_zero_periods();
        test_address_limits();
        test_traffic_no_idle();
        test_traffic_sender_idle();
        test_traffic_receiver_stall();
        test_traffic_both_idle();
        test_period_extremes();
        test_time_wrap();
        wait_drained();
        repeat (16) @(posedge aclk);
        $display("run covered %0d requests and %0d results: bring-up, refused starts,",
                 requests_sent, results_seen);
        $display("bus errors, address limits, periods zero to max, time wrap; %0s %0d %0d %0d %0d",
                 "init/cursor/page/on", kind_count[oprs_pkg::XFER_INIT],
                 kind_count[oprs_pkg::XFER_CURSOR], kind_count[oprs_pkg::XFER_PAGE],
                 kind_count[oprs_pkg::XFER_ON]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
